>>> rtl/core/lcg48_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg48_pkg: shared types and constants
// Operation codes, generator constants and the payload types of the channels.
// ----------------------------------------------------------------------------
package lcg48_pkg;

	localparam logic [47:0] LCG_MUL = 48'h0005_DEEC_E66D;
	localparam logic [47:0] LCG_ADD = 48'h0000_0000_000B;
	localparam logic [7:0] EXP_OFFSET = 8'd74;

	typedef enum logic [2:0] {
		OP_RESEED = 3'd0,
		OP_BITS   = 3'd1,
		OP_BOUND  = 3'd2,
		OP_LONG   = 3'd3,
		OP_FRAC   = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [63:0] seed_in;
		logic [5:0]         bit_count;
		logic signed [31:0] bound;
	} req_t;

	typedef struct packed {
		logic [63:0] value;
		logic        bad_bound;
	} rsp_t;

endpackage

>>> rtl/core/lcg48_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg48_req_if / lcg48_rsp_if: valid/ready channels
// One interface per direction, each carrying its payload struct.
// ----------------------------------------------------------------------------
interface lcg48_req_if;
	logic            valid;
	logic            ready;
	lcg48_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lcg48_rsp_if;
	logic            valid;
	logic            ready;
	lcg48_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/lcg48_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg48_alu: shared iterative arithmetic unit
// Shift-add multiplier (48x48 mod 2^48, 4 bits per cycle) and restoring
// divider (32-bit remainder, 1 bit per cycle), sharing the acc and mcand registers.
// ----------------------------------------------------------------------------
module lcg48_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start_mul,
	input  logic        start_div,
	input  logic [47:0] a,
	input  logic [47:0] b,
	output logic        done,
	output logic [47:0] result
);

	logic [47:0] acc_q;
	logic [47:0] mcand_q;
	logic [47:0] mplier_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        is_div_q;
	logic [31:0] quo_q;

	logic [47:0] madd;
	logic [32:0] trial;
	logic [31:0] rem_shift;

	// Multiply: add four partial products of the low nibble per cycle.
	always_comb begin
		madd = acc_q;
		for (int i = 0; i < 4; i++) begin
			if (mplier_q[i])
				madd = madd + (mcand_q << i);
		end
	end

	// Divide: remainder in acc_q[31:0], dividend bits shifted out of quo_q.
	assign rem_shift = {acc_q[30:0], quo_q[31]};
	assign trial = {1'b0, rem_shift} - {1'b0, mcand_q[31:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			is_div_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start_mul || start_div) begin
				busy_q <= 1'b1;
				is_div_q <= start_div;
				cnt_q <= start_div ? 6'd32 : 6'd12;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_mul || start_div) begin
			acc_q <= '0;
			mcand_q <= b;
			mplier_q <= a;
			quo_q <= a[31:0];
		end else if (busy_q) begin
			if (is_div_q) begin
				quo_q <= {quo_q[30:0], 1'b0};
				acc_q <= trial[32] ? {16'd0, rem_shift} : {16'd0, trial[31:0]};
			end else begin
				acc_q <= madd;
				mcand_q <= mcand_q << 4;
				mplier_q <= mplier_q >> 4;
			end
		end
	end

	assign result = acc_q;

endmodule

>>> rtl/core/lcg48_random_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg48_random_generator: 48-bit linear congruential random generator
// Reseed, raw bits, bounded int, 64-bit long and binary32 fraction ops.
// ----------------------------------------------------------------------------
// The block keeps a 48-bit state advanced as state * 0x5DEECE66D + 11 modulo
// 2^48, and every request transaction yields exactly one response
// transaction. A single shared arithmetic unit does the state advances and
// the divisions: each state advance is a 48-bit multiply that retires four
// multiplier bits per cycle, and the remainder for a bound that is not a
// power of two comes from a restoring divider that retires one quotient bit
// per cycle. A reseed, a bad bound or an unused op goes straight to the
// output register; a raw draw or a power-of-two bound takes one draw, a long
// or a fraction two (the fraction then normalizes one bit per cycle), and
// any other bound a draw and a division, repeated after a failed rejection
// test. The request side is not ready while an item is in flight; the
// response sits in an output register until taken, and a new request is
// taken only after that.
// ----------------------------------------------------------------------------
module lcg48_random_generator (
	input  logic               clk,
	input  logic               arst_n,
	lcg48_req_if.sink          req,
	lcg48_rsp_if.source        rsp
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_DRAW  = 8'b0000_0010,
		ST_WAIT  = 8'b0000_0100,
		ST_USE   = 8'b0000_1000,
		ST_DIV   = 8'b0001_0000,
		ST_DWAIT = 8'b0010_0000,
		ST_NORM  = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t      state_q;
	logic [47:0] lcg_q;
	lcg48_pkg::req_t req_q;
	logic [31:0] u_q;
	logic [31:0] hi_q;
	logic [52:0] frac_q;
	logic [5:0]  t_q;
	logic        second_q;
	logic [63:0] value_q;
	logic        bad_q;

	logic        start_mul;
	logic        start_div;
	logic        alu_done;
	logic [47:0] alu_res;
	logic [47:0] new_state;
	logic [31:0] draw31;
	logic [31:0] bnd;
	logic [31:0] bm1;
	logic [31:0] chk;
	logic [5:0]  nbits;
	logic [31:0] rawv;
	logic [63:0] bprod;

	lcg48_alu u_alu (
		.clk       (clk),
		.arst_n    (arst_n),
		.start_mul (start_mul),
		.start_div (start_div),
		.a         (lcg_q),
		.b         (state_q == ST_DIV ? {16'd0, bnd} : lcg48_pkg::LCG_MUL),
		.done      (alu_done),
		.result    (alu_res)
	);

	assign new_state = alu_res + lcg48_pkg::LCG_ADD;
	assign draw31 = {1'b0, new_state[47:17]};
	assign bnd = req_q.bound;
	assign bm1 = bnd - 32'd1;
	assign chk = u_q - alu_res[31:0] + bm1;
	assign nbits = (req_q.bit_count > 6'd32) ? 6'd32 : req_q.bit_count;
	assign rawv = (nbits == 6'd0) ? 32'd0 : 32'(new_state[47:16] >> (6'd32 - nbits));
	assign bprod = 64'(bnd) * 64'(draw31);

	assign start_mul = (state_q == ST_DRAW);
	assign start_div = (state_q == ST_DIV);
	// Division uses lcg_q as dividend, so the state is parked in lcg_keep_q.

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = (state_q == ST_OUT);
	assign rsp.data.value = value_q;
	assign rsp.data.bad_bound = bad_q;

	logic [47:0] lcg_keep_q;

	// Round a normalized 53-bit fraction (leading one at bit 52) to binary32.
	function automatic logic [31:0] round_f(input logic [52:0] f, input logic [5:0] t);
		logic [23:0] sig;
		logic [24:0] sr;
		logic [7:0]  ex;
		logic        up;
		sig = f[52:29];
		up = f[28] && (f[27:0] != '0 || f[29]);
		sr = {1'b0, sig} + {24'd0, up};
		ex = 8'(t) + lcg48_pkg::EXP_OFFSET;
		if (sr[24]) begin
			ex = ex + 8'd1;
			sr = sr >> 1;
		end
		round_f = {1'b0, ex, sr[22:0]};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lcg_q <= '0;
			lcg_keep_q <= '0;
			second_q <= 1'b0;
			req_q <= '0;
			u_q <= '0;
			hi_q <= '0;
			frac_q <= '0;
			t_q <= '0;
			value_q <= '0;
			bad_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						req_q <= req.data;
						value_q <= '0;
						bad_q <= 1'b0;
						second_q <= 1'b0;
						case (req.data.op)
							lcg48_pkg::OP_RESEED: begin
								lcg_q <= req.data.seed_in[47:0] ^ lcg48_pkg::LCG_MUL;
								state_q <= ST_OUT;
							end
							lcg48_pkg::OP_BITS, lcg48_pkg::OP_LONG,
							lcg48_pkg::OP_FRAC: state_q <= ST_DRAW;
							lcg48_pkg::OP_BOUND: begin
								if (req.data.bound[31] || req.data.bound == 32'sd0) begin
									bad_q <= 1'b1;
									state_q <= ST_OUT;
								end else begin
									state_q <= ST_DRAW;
								end
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_DRAW: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (alu_done) begin
						lcg_q <= new_state;
						state_q <= ST_USE;
					end
				end
				ST_USE: begin
					// Results of the last draw are in lcg_q.
					state_q <= ST_OUT;
					case (req_q.op)
						lcg48_pkg::OP_BITS: begin
							value_q <= {{32{rawv[31]}}, rawv};
						end
						lcg48_pkg::OP_LONG: begin
							if (!second_q) begin
								hi_q <= lcg_q[47:16];
								second_q <= 1'b1;
								state_q <= ST_DRAW;
							end else begin
								value_q <= {hi_q, 32'd0} + {{32{lcg_q[47]}}, lcg_q[47:16]};
							end
						end
						lcg48_pkg::OP_FRAC: begin
							if (!second_q) begin
								hi_q <= {6'd0, lcg_q[47:22]};
								second_q <= 1'b1;
								state_q <= ST_DRAW;
							end else begin
								frac_q <= {hi_q[25:0], lcg_q[47:21]};
								t_q <= 6'd52;
								state_q <= ST_NORM;
							end
						end
						lcg48_pkg::OP_BOUND: begin
							if ((bnd & bm1) == 32'd0) begin
								value_q <= {{32{bprod[62]}}, bprod[62:31]};
							end else begin
								u_q <= {1'b0, lcg_q[47:17]};
								lcg_keep_q <= lcg_q;
								lcg_q <= {17'd0, lcg_q[47:17]};
								state_q <= ST_DIV;
							end
						end
						default: ;
					endcase
				end
				ST_DIV: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (alu_done) begin
						lcg_q <= lcg_keep_q;
						if (chk[31]) begin
							state_q <= ST_DRAW;
						end else begin
							value_q <= {32'd0, alu_res[31:0]};
							state_q <= ST_OUT;
						end
					end
				end
				ST_NORM: begin
					// Shift left one bit per cycle until the leading one is at bit 52.
					if (frac_q == '0) begin
						value_q <= '0;
						state_q <= ST_OUT;
					end else if (!frac_q[52]) begin
						frac_q <= frac_q << 1;
						t_q <= t_q - 6'd1;
					end else begin
						value_q <= {32'd0, round_f(frac_q, t_q)};
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (rsp.ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	ap_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !rsp.valid)
		else $error("ready while a response is pending");
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(value_q))
		else $error("response changed before it was taken");
	ap_bad_nodraw: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.data.op == lcg48_pkg::OP_BOUND
		&& req.data.bound[31] |=> state_q == ST_OUT && $stable(lcg_q))
		else $error("bad bound advanced the state");

endmodule
